>>> rtl/ita_pkg.sv
package ita_pkg;

    localparam int VALUE_W    = 32;
    localparam int CMD_W      = 2;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int MAX_DIGITS = 10;
    localparam int DEPTH_W    = $clog2(MAX_DIGITS + 1);

    // limits on digit count per radix
    localparam logic [DEPTH_W-1:0] DEC_DIGITS = DEPTH_W'(10);
    localparam logic [DEPTH_W-1:0] HEX_DIGITS = DEPTH_W'(8);

    // reciprocal of ten: q = (x * RECIP_10) >> RECIP_SHIFT is exact for 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // format commands
    localparam logic [CMD_W-1:0] CMD_DEC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_HEX_LO = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HEX_UP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PTR    = 2'd3;

    localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CHR_A_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_A_UPPER = 8'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPLIT,
        ST_PFX0,
        ST_PFXX,
        ST_EMIT
    } state_t;

    // stack control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

    // digit value to its ascii code
    function automatic logic [CHAR_W-1:0] digit_to_ascii(
        input logic [DIGIT_W-1:0] d,
        input logic               upper
    );
        logic [CHAR_W-1:0] base;
        base = upper ? CHR_A_UPPER : CHR_A_LOWER;
        if (d < DIGIT_W'(10))
            return CHR_ZERO + CHAR_W'(d);
        else
            return base + CHAR_W'(d) - CHAR_W'(10);
    endfunction

endpackage

>>> rtl/ita_digit_unit.sv
module ita_digit_unit
    import ita_pkg::*;
(
    input  logic               clk,
    input  logic               mul_en,
    input  logic               is_dec,
    input  logic [VALUE_W-1:0] x,
    output logic [VALUE_W-1:0] quotient,
    output logic [DIGIT_W-1:0] digit
);

    logic [2*VALUE_W-1:0] prod_reg;
    logic [VALUE_W-1:0]   q_dec;
    logic [VALUE_W-1:0]   r_dec;

    // reciprocal multiply, registered before the split
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= {{VALUE_W{1'b0}}, x} * {{VALUE_W{1'b0}}, RECIP_10};
        end
    end

    // quotient and remainder; remainder is x - 8q - 2q
    assign q_dec = VALUE_W'(prod_reg[2*VALUE_W-1:RECIP_SHIFT]);
    assign r_dec = x - (q_dec << 3) - (q_dec << 1);

    assign quotient = is_dec ? q_dec : (x >> DIGIT_W);
    assign digit    = is_dec ? r_dec[DIGIT_W-1:0] : x[DIGIT_W-1:0];

endmodule

>>> rtl/ita_digit_stack.sv
module ita_digit_stack
    import ita_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  stack_ctrl_t        ctrl,
    input  logic [DIGIT_W-1:0] push_digit,
    output logic [DIGIT_W-1:0] top_digit,
    output logic [DEPTH_W-1:0] depth
);

    logic [DIGIT_W-1:0] stack_reg [MAX_DIGITS];
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;

    // entries shift up on push, down on pop
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            for (int i = MAX_DIGITS - 1; i > 0; i--)
                stack_reg[i] <= stack_reg[i-1];
            stack_reg[0] <= push_digit;
        end
        else if (ctrl.pop)
        begin
            for (int i = 0; i < MAX_DIGITS - 1; i++)
                stack_reg[i] <= stack_reg[i+1];
        end
    end

    // fill level
    always_comb
    begin
        depth_next = depth_reg;
        if (ctrl.push)
            depth_next = depth_reg + DEPTH_W'(1);
        else if (ctrl.pop)
            depth_next = depth_reg - DEPTH_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= '0;
        else
            depth_reg <= depth_next;
    end

    assign top_digit = stack_reg[0];
    assign depth     = depth_reg;

endmodule

>>> rtl/integer_to_ascii_formatter_core.sv
// channel | signals                            | direction
// --------+------------------------------------+----------
// in      | in_valid, in_ready, value, command | to core
// out     | out_valid, out_ready, character,   | from core
//         | last                               |
//
// a number is accepted in the idle state; each digit then passes through the
// shared divide unit (multiply, then split), and each character goes out
// through the output register (one per digit, plus two for the 0x prefix)
// in_ready is high only when the sequencer is idle; a stalled out beat holds
// the sequencer in its emit states
// rst_n clears the sequencer, the digit count and the output valid
module integer_to_ascii_formatter_core
    import ita_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    input  logic [CMD_W-1:0]   command,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  character,
    output logic               last
);

    state_t             state_reg;
    state_t             state_next;
    logic [VALUE_W-1:0] num_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  character_reg;
    logic               last_reg;

    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] digit;
    logic [DIGIT_W-1:0] top_digit;
    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] limit;
    stack_ctrl_t        stack_ctrl;
    logic               mul_en;
    logic               is_dec;
    logic               conv_done;
    logic               out_free;
    logic               load_out;
    logic [CHAR_W-1:0]  load_char;
    logic               load_last;

    assign is_dec    = (cmd_reg == CMD_DEC);
    assign limit     = is_dec ? DEC_DIGITS : HEX_DIGITS;
    assign conv_done = (quotient == '0) || (depth + DEPTH_W'(1) == limit);
    assign out_free  = !out_valid_reg || out_ready;

    // shared divide unit
    ita_digit_unit u_digit_unit (
        .clk      (clk),
        .mul_en   (mul_en),
        .is_dec   (is_dec),
        .x        (num_reg),
        .quotient (quotient),
        .digit    (digit)
    );

    // digit stack reverses digit order
    ita_digit_stack u_digit_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stack_ctrl),
        .push_digit (digit),
        .top_digit  (top_digit),
        .depth      (depth)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_SPLIT;
            ST_SPLIT:
                if (conv_done)
                    state_next = (cmd_reg == CMD_PTR) ? ST_PFX0 : ST_EMIT;
                else
                    state_next = ST_MUL;
            ST_PFX0:
                if (out_free)
                    state_next = ST_PFXX;
            ST_PFXX:
                if (out_free)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_free && depth == DEPTH_W'(1))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready        = 1'b0;
        mul_en          = 1'b0;
        stack_ctrl.push = 1'b0;
        stack_ctrl.pop  = 1'b0;
        load_out        = 1'b0;
        load_char       = CHR_ZERO;
        load_last       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_MUL:
                mul_en = 1'b1;
            ST_SPLIT:
                stack_ctrl.push = 1'b1;
            ST_PFX0:
            begin
                load_out  = out_free;
                load_char = CHR_ZERO;
            end
            ST_PFXX:
            begin
                load_out  = out_free;
                load_char = CHR_X;
            end
            ST_EMIT:
            begin
                load_out       = out_free;
                stack_ctrl.pop = out_free;
                load_char      = digit_to_ascii(top_digit, cmd_reg == CMD_HEX_UP);
                load_last      = (depth == DEPTH_W'(1));
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // working value and command
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            num_reg <= value;
            cmd_reg <= command;
        end
        else if (stack_ctrl.push)
        begin
            num_reg <= quotient;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            character_reg <= load_char;
            last_reg      <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

endmodule

>>> rtl/ita_checker.sv
module ita_checker
    import ita_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] character,
    input logic              last
);

    // stalled out beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
        else $error("stalled out beat changed");

    // after a number is accepted, in_ready stays low through the multiply and split states
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("core ready too soon after accepting a number");

    // a new number is taken only once the previous text is fully queued
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || last)
        else $error("number accepted while text still pending");

endmodule

bind integer_to_ascii_formatter_core ita_checker u_ita_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
);

>>> sim/integer_to_ascii_formatter_core_tb.sv
module integer_to_ascii_formatter_core_tb;
    import ita_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_NUMBERS = 360;
    localparam int MAX_REPORTS = 100;

    // one expected character of a number's text
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } text_char_t;

    // expected text of every accepted number, checked beat by beat
    class text_scoreboard;
        text_char_t expected_text_q[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // format one accepted number into its expected characters
        function void note_number(logic [VALUE_W-1:0] v, logic [CMD_W-1:0] c);
            logic [CHAR_W-1:0] rev [MAX_DIGITS];
            logic [VALUE_W-1:0] n;
            int                 nd;
            string              tab;
            text_char_t         e;
            n  = v;
            nd = 0;
            if (c == CMD_DEC)
            begin
                do
                begin
                    rev[nd] = CHR_ZERO + CHAR_W'(n % 10);
                    nd++;
                    n = n / 10;
                end while (n != 0 && nd < MAX_DIGITS);
            end
            else
            begin
                tab = (c == CMD_HEX_UP) ? "0123456789ABCDEF" : "0123456789abcdef";
                do
                begin
                    rev[nd] = tab[int'(n[3:0])];
                    nd++;
                    n = n >> 4;
                end while (n != 0 && nd < 8);
            end
            // pointer form starts with the 0x prefix
            if (c == CMD_PTR)
            begin
                e.ch = CHR_ZERO;
                e.is_last = 1'b0;
                expected_text_q.push_back(e);
                e.ch = CHR_X;
                expected_text_q.push_back(e);
            end
            // most significant digit first, last flag on the final one
            for (int i = nd - 1; i >= 0; i--)
            begin
                e.ch = rev[i];
                e.is_last = (i == 0);
                expected_text_q.push_back(e);
            end
        endfunction

        // compare one output beat with the oldest expected character
        function void check_char(logic [CHAR_W-1:0] ch, logic is_last);
            text_char_t e;
            if (expected_text_q.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                             $time, ch, is_last);
                errors++;
                return;
            end
            e = expected_text_q.pop_front();
            if (ch !== e.ch)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: character mismatch: expected 0x%02h, actual 0x%02h",
                             $time, e.ch, ch);
                errors++;
            end
            if (is_last !== e.is_last)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, e.is_last, is_last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_text_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] value;
    logic [CMD_W-1:0]   command;
    logic               out_valid;
    logic               out_ready;
    logic [CHAR_W-1:0]  character;
    logic               last;

    text_scoreboard sb;
    bit             calm;
    int             idle_cycles;

    integer_to_ascii_formatter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one number, with a random gap before it, and wait for its beat
    task automatic send_number(input logic [VALUE_W-1:0] v, input logic [CMD_W-1:0] c);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        value    = v;
        command  = c;
        do @(posedge clk); while (!in_ready);
    endtask

    // accept characters forever, with random stalls between beats
    task automatic take_characters();
        int stall;
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    endtask

    // beat monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_number(value, command);
            if (out_valid && out_ready)
                sb.check_char(character, last);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d characters outstanding",
                     $time, sb.outstanding());
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        take_characters();
    end

    // reset, stimulus and end of run
    initial
    begin
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        int                 k;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        value         = '0;
        command       = CMD_DEC;
        calm          = 1'b0;
        idle_cycles   = 0;
        sb            = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // zero and all ones in every form
        send_number(32'd0, CMD_DEC);
        send_number(32'd0, CMD_HEX_LO);
        send_number(32'd0, CMD_HEX_UP);
        send_number(32'd0, CMD_PTR);
        send_number(32'hFFFF_FFFF, CMD_DEC);
        send_number(32'hFFFF_FFFF, CMD_HEX_LO);
        send_number(32'hFFFF_FFFF, CMD_HEX_UP);
        send_number(32'hFFFF_FFFF, CMD_PTR);
        // decimal digit count boundaries
        send_number(32'd9, CMD_DEC);
        send_number(32'd10, CMD_DEC);
        send_number(32'd999_999_999, CMD_DEC);
        send_number(32'd1_000_000_000, CMD_DEC);
        send_number(32'h8000_0000, CMD_DEC);
        // hex digit count boundaries and letter case
        send_number(32'hF, CMD_HEX_LO);
        send_number(32'h10, CMD_HEX_UP);
        send_number(32'hDEAD_BEEF, CMD_HEX_LO);
        send_number(32'hDEAD_BEEF, CMD_HEX_UP);
        send_number(32'h0FFF_FFFF, CMD_HEX_UP);
        send_number(32'h1000_0000, CMD_PTR);
        send_number(32'h1, CMD_PTR);
        send_number(32'hABCD_EF01, CMD_PTR);

        // random numbers, with stretches of no idling on either side
        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            calm = ((i / 60) % 3) == 1;
            case ($urandom_range(0, 5))
                1:
                begin
                    k = $urandom_range(1, 32);
                    v = $urandom >> (32 - k);
                end
                2:
                begin
                    // around a power of ten
                    p = 1;
                    repeat ($urandom_range(0, 9)) p = p * 10;
                    v = p + VALUE_W'($urandom_range(0, 2)) - 1;
                end
                3:
                begin
                    // around a power of sixteen
                    k = $urandom_range(0, 7);
                    v = (32'h1 << (4 * k)) - VALUE_W'($urandom_range(0, 1));
                end
                4: v = $urandom_range(0, 20);
                default: v = $urandom;
            endcase
            send_number(v, CMD_W'($urandom_range(0, 3)));
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid = 1'b0;

        // drain the remaining text, then watch for stray beats
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            $display("%0t: %0d characters never arrived", $time, sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/ita_pkg.sv
rtl/ita_digit_unit.sv
rtl/ita_digit_stack.sv
rtl/integer_to_ascii_formatter_core.sv
rtl/ita_checker.sv
sim/integer_to_ascii_formatter_core_tb.sv
